/* hw/rtl/kfri_pkg.sv */
// shared types, constants and command tables for the keypad frame relay
package kfri_pkg;

  localparam int MAX_FRAME_DEF = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CMD_LEN       = 6;

  localparam int FUNC_W     = 3;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int INTERVAL_W = 16;
  localparam int COUNT_W    = 4;
  localparam int TLEN_W     = 3;

  localparam logic [7:0] BYTE_SOF   = 8'hAA;
  localparam logic [7:0] TYPE_LONG  = 8'hFF;
  localparam logic [7:0] TYPE_SHORT = 8'hF4;

  localparam logic [TLEN_W-1:0] LEN_LONG  = 3'd6;
  localparam logic [TLEN_W-1:0] LEN_SHORT = 3'd4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [COUNT_W-1:0]    COUNT_RST    = 4'd3;
  localparam logic [INTERVAL_W-1:0] TICKS_MAX    = 16'hFFFF;

  localparam logic PORT_BOX    = 1'b0;
  localparam logic PORT_KEYPAD = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEYPAD = 3'd0,
    FUNC_BOX    = 3'd1,
    FUNC_TICK   = 3'd2,
    FUNC_UP     = 3'd3,
    FUNC_DOWN   = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL = 1'd0,
    REG_COUNT    = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_BYTE     = 2'd0,
    JOB_FRAME    = 2'd1,
    JOB_CMD_UP   = 2'd2,
    JOB_CMD_DOWN = 2'd3
  } job_kind_t;

  // fixed move commands sent to the control box
  function automatic logic [7:0] cmd_byte(input logic down, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = BYTE_SOF;
      3'd1:    b = TYPE_LONG;
      3'd2:    b = 8'h00;
      3'd3:    b = down ? 8'h60 : 8'h50;
      3'd4:    b = down ? 8'h29 : 8'h2B;
      3'd5:    b = down ? 8'h64 : 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/kfri_front.sv */
// front end: classifies items, assembles keypad frames, runs the inject timer
module kfri_front #(
  parameter int MAX_FRAME = kfri_pkg::MAX_FRAME_DEF,
  parameter int LEN_W     = 3,
  parameter int JOB_W     = 2 + LEN_W + 8 * MAX_FRAME
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [kfri_pkg::FUNC_W-1:0]    func,
  input  logic [7:0]                     data_byte,
  input  logic                           cfg_we,
  input  logic [kfri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kfri_pkg::CFG_W-1:0]     cfg_data,
  output logic                           job_valid,
  output logic [JOB_W-1:0]               job
);
  import kfri_pkg::*;

  localparam int FILL_W = $clog2(MAX_FRAME + 1);
  localparam int IDX_F  = $clog2(MAX_FRAME);

  logic [7:0]            store [MAX_FRAME];
  logic [FILL_W-1:0]     fill, fill_next;
  logic                  in_frame, in_frame_next;
  logic [TLEN_W-1:0]     tlen, tlen_next;
  logic                  injecting, injecting_next;
  logic                  inject_down, inject_down_next;
  logic [COUNT_W-1:0]    sends_done, sends_done_next;
  logic [INTERVAL_W-1:0] ticks, ticks_next;
  logic [INTERVAL_W-1:0] interval;
  logic [COUNT_W-1:0]    count;

  logic                  start;
  logic [FILL_W-1:0]     fill0, fill1;
  logic [TLEN_W-1:0]     tlen1;
  logic                  room;
  logic [INTERVAL_W-1:0] ticks1;
  logic                  store_we;
  job_kind_t             job_kind;
  logic [LEN_W-1:0]      job_len;
  logic [8*MAX_FRAME-1:0] job_bytes;

  assign start  = (data_byte == BYTE_SOF) && !in_frame;
  assign fill0  = start ? '0 : fill;
  assign room   = fill0 < FILL_W'(MAX_FRAME);
  assign fill1  = room ? fill0 + FILL_W'(1) : fill0;
  assign ticks1 = (ticks == TICKS_MAX) ? ticks : ticks + INTERVAL_W'(1);

  // type byte is the one just taken when the fill reaches two
  always_comb begin
    tlen1 = start ? '0 : tlen;
    if (fill1 == FILL_W'(2)) begin
      if (data_byte == TYPE_LONG) tlen1 = LEN_LONG;
      else if (data_byte == TYPE_SHORT) tlen1 = LEN_SHORT;
    end
  end

  // frame contents including the byte being written this cycle
  always_comb begin
    for (int i = 0; i < MAX_FRAME; i++) begin
      if (room && fill0 == FILL_W'(i)) job_bytes[i*8 +: 8] = data_byte;
      else job_bytes[i*8 +: 8] = store[i];
    end
  end

  always_comb begin
    fill_next        = fill;
    in_frame_next    = in_frame;
    tlen_next        = tlen;
    injecting_next   = injecting;
    inject_down_next = inject_down;
    sends_done_next  = sends_done;
    ticks_next       = ticks;
    store_we         = 1'b0;
    job_valid        = 1'b0;
    job_kind         = JOB_BYTE;
    job_len          = LEN_W'(1);
    if (take) begin
      case (func_t'(func))
        FUNC_KEYPAD: begin
          if (!injecting && (in_frame || start)) begin
            store_we      = room;
            in_frame_next = 1'b1;
            fill_next     = fill1;
            tlen_next     = tlen1;
            if (fill1 == FILL_W'(2) && tlen1 == '0) begin
              in_frame_next = 1'b0;
              fill_next     = '0;
            end else if (tlen1 != '0 && FILL_W'(tlen1) == fill1) begin
              job_valid     = 1'b1;
              job_kind      = JOB_FRAME;
              job_len       = LEN_W'(fill1);
              in_frame_next = 1'b0;
              fill_next     = '0;
            end else if (fill1 >= FILL_W'(MAX_FRAME)) begin
              in_frame_next = 1'b0;
              fill_next     = '0;
            end
          end
        end
        FUNC_BOX: begin
          job_valid = 1'b1;
        end
        FUNC_TICK: begin
          ticks_next = ticks1;
          if (injecting && ticks1 >= interval) begin
            if (sends_done < count) begin
              sends_done_next = sends_done + COUNT_W'(1);
              ticks_next      = '0;
              job_valid       = 1'b1;
              job_kind        = inject_down ? JOB_CMD_DOWN : JOB_CMD_UP;
              job_len         = LEN_W'(CMD_LEN);
            end else begin
              injecting_next = 1'b0;
            end
          end
        end
        FUNC_UP, FUNC_DOWN: begin
          injecting_next   = 1'b1;
          inject_down_next = (func_t'(func) == FUNC_DOWN);
          sends_done_next  = '0;
          ticks_next       = '0;
        end
        default: ;
      endcase
    end
  end

  // a passed-through byte always travels in the lowest byte lane
  assign job = {job_kind, job_len,
                (job_kind == JOB_BYTE) ? {job_bytes[8*MAX_FRAME-1:8], data_byte} : job_bytes};

  always_ff @(posedge clk) begin
    if (store_we) store[fill0[IDX_F-1:0]] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      in_frame    <= 1'b0;
      tlen        <= '0;
      injecting   <= 1'b0;
      inject_down <= 1'b0;
      sends_done  <= '0;
      ticks       <= '0;
      interval    <= INTERVAL_RST;
      count       <= COUNT_RST;
    end else begin
      fill        <= fill_next;
      in_frame    <= in_frame_next;
      tlen        <= tlen_next;
      injecting   <= injecting_next;
      inject_down <= inject_down_next;
      sends_done  <= sends_done_next;
      ticks       <= ticks_next;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_INTERVAL: interval <= cfg_data[INTERVAL_W-1:0];
          REG_COUNT:    count    <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/kfri_queue.sv */
// short job queue between the front end and the byte sender
module kfri_queue #(
  parameter int W     = 8,
  parameter int DEPTH = kfri_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] data
);
  import kfri_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign valid   = count != '0;
  assign data    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/kfri_back.sv */
// back end: walks one job at a time and sends its bytes in order
module kfri_back #(
  parameter int MAX_FRAME = kfri_pkg::MAX_FRAME_DEF,
  parameter int LEN_W     = 3,
  parameter int IDX_W     = 3,
  parameter int JOB_W     = 2 + LEN_W + 8 * MAX_FRAME
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [JOB_W-1:0] q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_port,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import kfri_pkg::*;

  logic                   cur_valid;
  job_kind_t              cur_kind;
  logic [LEN_W-1:0]       cur_len;
  logic [8*MAX_FRAME-1:0] cur_bytes;
  logic [IDX_W-1:0]       idx;
  logic                   xfer;

  assign out_valid = cur_valid;
  assign xfer      = cur_valid && out_ready;
  assign out_last  = (LEN_W'(idx) + LEN_W'(1)) == cur_len;
  assign q_pop     = q_valid && (!cur_valid || (xfer && out_last));

  always_comb begin
    out_port = PORT_BOX;
    out_byte = 8'h00;
    case (cur_kind)
      JOB_BYTE: begin
        out_port = PORT_KEYPAD;
        out_byte = cur_bytes[7:0];
      end
      JOB_FRAME:    out_byte = cur_bytes[idx*8 +: 8];
      JOB_CMD_UP:   out_byte = cmd_byte(1'b0, idx[2:0]);
      JOB_CMD_DOWN: out_byte = cmd_byte(1'b1, idx[2:0]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_kind  <= job_kind_t'(q_data[JOB_W-1 -: 2]);
      cur_len   <= q_data[8*MAX_FRAME +: LEN_W];
      cur_bytes <= q_data[8*MAX_FRAME-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (xfer) begin
      if (out_last) cur_valid <= 1'b0;
      else idx <= idx + IDX_W'(1);
    end
  end

endmodule

/* hw/rtl/keypad_frame_relay_injector.sv */
// top level of the keypad frame relay with move command injection
//
//   channel  dir  handshake                    contents
//   s_axis   in   s_axis_tvalid/tready         tuser: func, tdata: data_byte
//   m_axis   out  m_axis_tvalid/tready         tuser: port, tdata: out_byte, tlast: last
//   cfg      in   cfg_we (no wait)             cfg_index selects register, cfg_data value
//
// the front end takes one input item per cycle while the job queue has room;
// the back end sends one byte per cycle while the output is ready; a frame is
// four or six bytes, an injected command six and a passed-through byte one
// rst is synchronous and clears all control state, with no clearing pass
// either side stalls alone: the queue holds up to two jobs between them
module keypad_frame_relay_injector #(
  parameter int MAX_FRAME = kfri_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic [kfri_pkg::FUNC_W-1:0]    s_axis_tuser,  // [2:0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic                           m_axis_tuser,  // [0] port
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [kfri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kfri_pkg::CFG_W-1:0]     cfg_data
);
  import kfri_pkg::*;

  localparam int RUN_MAX = (MAX_FRAME > CMD_LEN) ? MAX_FRAME : CMD_LEN;
  localparam int LEN_W   = $clog2(RUN_MAX + 1);
  localparam int IDX_W   = $clog2(RUN_MAX);
  localparam int JOB_W   = 2 + LEN_W + 8 * MAX_FRAME;

  logic             take;
  logic             job_valid;
  logic [JOB_W-1:0] job;
  logic             q_full, q_valid, q_pop;
  logic [JOB_W-1:0] q_data;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  kfri_front #(
    .MAX_FRAME(MAX_FRAME),
    .LEN_W    (LEN_W),
    .JOB_W    (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .func     (s_axis_tuser),
    .data_byte(s_axis_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job_valid(job_valid),
    .job      (job)
  );

  kfri_queue #(
    .W    (JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_data(job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .data     (q_data)
  );

  kfri_back #(
    .MAX_FRAME(MAX_FRAME),
    .LEN_W    (LEN_W),
    .IDX_W    (IDX_W),
    .JOB_W    (JOB_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_port (m_axis_tuser),
    .out_byte (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule
